// ===== hw/rtl/prpe_pkg.sv =====
`default_nettype none
package prpe_pkg;

   localparam int LocalNodes  = 4096;
   localparam int GlobalNodes = 65536;
   localparam int EdgeDepth   = 65536;
   localparam int ScoreBits   = 32;

   localparam int LiW    = $clog2(LocalNodes);
   localparam int NodeW  = $clog2(GlobalNodes);
   localparam int EdgeW  = $clog2(EdgeDepth);
   localparam int BoundW = 17;

   typedef logic [ScoreBits-1:0] score_type;

   typedef enum logic [2:0] {
      ACT_LOAD_BOUND = 3'd0,
      ACT_LOAD_EDGE  = 3'd1,
      ACT_LOAD_NODE  = 3'd2,
      ACT_SEND       = 3'd3,
      ACT_REMOTE     = 3'd4,
      ACT_FINISH     = 3'd5,
      ACT_CLEAR      = 3'd6,
      ACT_END_ITER   = 3'd7
   } action_type;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_MSG   = 2'd1;
   localparam logic [1:0] KIND_SCORE = 2'd2;
   localparam logic [1:0] KIND_ITER  = 2'd3;

   localparam logic [1:0] CSR_TOTAL_NODES = 2'd0;
   localparam logic [1:0] CSR_FIRST_NODE  = 2'd1;
   localparam logic [1:0] CSR_DAMPING     = 2'd2;
   localparam logic [1:0] CSR_ITER_LIMIT  = 2'd3;

   // saturating add at all ones
   function automatic score_type sat_add(input score_type a, input score_type b);
      logic [ScoreBits:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ScoreBits] ? {ScoreBits{1'b1}} : s[ScoreBits-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/prpe_ram.sv =====
`default_nettype none
module prpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pagerank_partition_engine.sv =====
// Channel   | Ports                                   | Handshake
// request   | req_action .. req_importance            | start, taken when busy low
// response  | rsp_kind .. rsp_more_iterations         | rsp_strobe, one cycle, no stall
// csr write | csr_index, csr_data                     | csr_valid / csr_ready (always ready)
//
// After reset busy stays high while the range table and both sums clear.
// Bound, edge, clear and end of iteration finish in the accept cycle; load node and finish
// divide; a send reads the node info, then divides unless its degree is zero and may scatter;
// remote importance walks the edge range. A walked edge passes S_E1, S_E2 and S_E3, or only
// S_E1 and S_E2 if its target is foreign. The shared divider has 32 restoring steps.
// The response comes in the cycle after the work ends; the receiver cannot stall it.
`default_nettype none
module pagerank_partition_engine
   import prpe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_node_id,
   input  wire logic [11:0] req_local_index,
   input  wire logic [16:0] req_value,
   input  wire logic [15:0] req_degree,
   input  wire logic signed [15:0] req_target_part,
   input  wire logic        req_update_local,
   input  wire logic [31:0] req_importance,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_kind,
   output logic [14:0]      rsp_part,
   output logic [15:0]      rsp_node_out,
   output logic [31:0]      rsp_amount,
   output logic             rsp_more_iterations,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam logic [3:0] S_CLR      = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SEND_RD  = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_DIV_DONE = 4'd4;
   localparam logic [3:0] S_RANGE_RD = 4'd5;
   localparam logic [3:0] S_E1       = 4'd6;
   localparam logic [3:0] S_E2       = 4'd7;
   localparam logic [3:0] S_E3       = 4'd8;
   localparam logic [3:0] S_SEND_MSG = 4'd9;
   localparam logic [3:0] S_FIN_RD   = 4'd10;
   localparam logic [3:0] S_FIN_MUL  = 4'd11;

   // configuration
   logic [16:0] total_ff, total_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] damp_ff, damp_in;
   logic [7:0]  limit_ff, limit_in;

   logic [3:0]  state_ff, state_in;
   action_type  act_ff, act_in;
   logic [LiW-1:0] li_ff, li_in;
   score_type   imp_ff, imp_in;
   logic [BoundW-1:0] prev_ff, prev_in;
   logic [EdgeW:0]    fill_ff, fill_in;
   logic [7:0]  iter_ff, iter_in;
   logic [NodeW-1:0]  clr_ff, clr_in;
   logic [BoundW-1:0] e_ff, e_in;
   logic [BoundW-1:0] hi_ff, hi_in;
   logic [LiW-1:0]    t_ff, t_in;
   logic [15:0] part_ff, part_in;
   logic        flag_ff, flag_in;
   score_type   sum_ff, sum_in;
   logic [48:0] prod_ff, prod_in;

   // shared divider
   logic [16:0] rem_ff, rem_in;
   score_type   quo_ff, quo_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [14:0] rsp_part_ff, rsp_part_in;
   logic [15:0] rsp_node_ff, rsp_node_in;
   score_type   rsp_amount_ff, rsp_amount_in;
   logic        rsp_more_ff, rsp_more_in;

   // memory ports
   logic        score_we, send_we, recv_we, info_we, range_we, edge_we;
   logic [LiW-1:0] score_wa, send_wa, recv_wa, info_wa, send_ra, recv_ra;
   score_type   score_wd, send_wd, recv_wd, score_rd, send_rd, recv_rd;
   logic [32:0] info_wd, info_rd;
   logic [NodeW-1:0] range_wa, range_ra;
   logic [33:0] range_wd, range_rd;
   logic [EdgeW-1:0] edge_wa, edge_ra;
   logic [16:0] edge_wd, edge_rd;

   logic [16:0] n_div;
   logic [16:0] orig;
   logic [17:0] div_sh;
   logic [16:0] tgt;
   logic [7:0]  iter_next;
   score_type   acc_new;

   prpe_ram #(.WIDTH(ScoreBits), .DEPTH(LocalNodes)) u_score (
      .clock(clock), .we(score_we), .waddr(score_wa), .wdata(score_wd),
      .raddr(req_local_index), .rdata(score_rd));
   prpe_ram #(.WIDTH(ScoreBits), .DEPTH(LocalNodes)) u_send (
      .clock(clock), .we(send_we), .waddr(send_wa), .wdata(send_wd),
      .raddr(send_ra), .rdata(send_rd));
   prpe_ram #(.WIDTH(ScoreBits), .DEPTH(LocalNodes)) u_recv (
      .clock(clock), .we(recv_we), .waddr(recv_wa), .wdata(recv_wd),
      .raddr(recv_ra), .rdata(recv_rd));
   prpe_ram #(.WIDTH(33), .DEPTH(LocalNodes)) u_info (
      .clock(clock), .we(info_we), .waddr(info_wa), .wdata(info_wd),
      .raddr(req_local_index), .rdata(info_rd));
   prpe_ram #(.WIDTH(34), .DEPTH(GlobalNodes)) u_range (
      .clock(clock), .we(range_we), .waddr(range_wa), .wdata(range_wd),
      .raddr(range_ra), .rdata(range_rd));
   prpe_ram #(.WIDTH(17), .DEPTH(EdgeDepth)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
      .raddr(edge_ra), .rdata(edge_rd));

   assign busy                = (state_ff != S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_part            = rsp_part_ff;
   assign rsp_node_out        = rsp_node_ff;
   assign rsp_amount          = rsp_amount_ff;
   assign rsp_more_iterations = rsp_more_ff;

   assign n_div     = (total_ff == 17'd0) ? 17'd1 : total_ff;
   assign orig      = {1'b0, first_ff} + {5'd0, li_ff};
   assign div_sh    = {rem_ff, quo_ff[ScoreBits-1]};
   assign tgt       = edge_rd - {1'b0, first_ff};
   assign iter_next = (iter_ff == 8'hFF) ? iter_ff : iter_ff + 8'd1;
   assign acc_new   = sat_add((act_ff == ACT_REMOTE) ? recv_rd : send_rd,
                              (act_ff == ACT_REMOTE) ? imp_ff : quo_ff);

   always_comb begin
      total_in = total_ff;  first_in = first_ff;  damp_in = damp_ff;  limit_in = limit_ff;
      state_in = state_ff;  act_in = act_ff;  li_in = li_ff;  imp_in = imp_ff;
      prev_in = prev_ff;  fill_in = fill_ff;  iter_in = iter_ff;  clr_in = clr_ff;
      e_in = e_ff;  hi_in = hi_ff;  t_in = t_ff;  part_in = part_ff;  flag_in = flag_ff;
      sum_in = sum_ff;  prod_in = prod_ff;
      rem_in = rem_ff;  quo_in = quo_ff;  dvs_in = dvs_ff;  cnt_in = cnt_ff;
      rsp_strobe_in = 1'b0;  rsp_kind_in = KIND_ACK;  rsp_part_in = '0;
      rsp_node_in = '0;  rsp_amount_in = '0;  rsp_more_in = 1'b0;

      score_we = 1'b0;  score_wa = li_ff;  score_wd = quo_ff;
      send_we = 1'b0;   send_wa = t_ff;    send_wd = acc_new;
      recv_we = 1'b0;   recv_wa = t_ff;    recv_wd = acc_new;
      info_we = 1'b0;   info_wa = req_local_index;
      info_wd = {req_degree, req_target_part, req_update_local};
      range_we = 1'b0;  range_wa = req_node_id;  range_wd = {prev_ff, req_value};
      edge_we = 1'b0;   edge_wa = fill_ff[EdgeW-1:0];  edge_wd = req_value;
      send_ra = req_local_index;  recv_ra = req_local_index;
      range_ra = req_node_id;
      edge_ra = e_ff[EdgeW-1:0];

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOTAL_NODES: total_in = csr_data;
            CSR_FIRST_NODE:  first_in = csr_data[15:0];
            CSR_DAMPING:     damp_in  = csr_data[15:0];
            CSR_ITER_LIMIT:  limit_in = csr_data[7:0];
            default:         total_in = total_ff;
         endcase
      end

      unique case (state_ff)
         S_CLR: begin
            // sweep ranges and both accumulators to zero
            range_we = 1'b1;  range_wa = clr_ff;  range_wd = '0;
            send_we = 1'b1;   send_wa = clr_ff[LiW-1:0];  send_wd = '0;
            recv_we = 1'b1;   recv_wa = clr_ff[LiW-1:0];  recv_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {NodeW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               act_in = action_type'(req_action);
               li_in  = req_local_index;
               imp_in = req_importance;
               unique case (action_type'(req_action))
                  ACT_LOAD_BOUND: begin
                     range_we = 1'b1;
                     prev_in  = req_value;
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_LOAD_EDGE: begin
                     if (!fill_ff[EdgeW]) begin
                        edge_we = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_LOAD_NODE: begin
                     info_we  = 1'b1;
                     quo_in   = score_type'(1) << (ScoreBits - 2);
                     dvs_in   = n_div;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
                  ACT_SEND: state_in = S_SEND_RD;
                  ACT_REMOTE: state_in = S_RANGE_RD;
                  ACT_FINISH: state_in = S_FIN_RD;
                  ACT_CLEAR: begin
                     send_we = 1'b1;  send_wa = req_local_index;  send_wd = '0;
                     recv_we = 1'b1;  recv_wa = req_local_index;  recv_wd = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_END_ITER: begin
                     iter_in = iter_next;
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in = KIND_ITER;
                     rsp_more_in = (iter_next < limit_ff);
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEND_RD: begin
            part_in = info_rd[16:1];
            flag_in = info_rd[0];
            if (info_rd[32:17] == 16'd0) begin
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               quo_in   = score_rd;
               dvs_in   = {1'b0, info_rd[32:17]};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring step a cycle
            if (div_sh >= {1'b0, dvs_ff}) begin
               rem_in = 17'(div_sh - {1'b0, dvs_ff});
               quo_in = {quo_ff[ScoreBits-2:0], 1'b1};
            end else begin
               rem_in = div_sh[16:0];
               quo_in = {quo_ff[ScoreBits-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            priority if (act_ff == ACT_LOAD_NODE) begin
               score_we = 1'b1;
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else if (act_ff == ACT_SEND) begin
               if (flag_ff && !orig[16]) begin
                  range_ra = orig[NodeW-1:0];
                  state_in = S_RANGE_RD;
               end else begin
                  state_in = S_SEND_MSG;
               end
            end else begin
               score_we = 1'b1;
               score_wd = sat_add(prod_ff[47:16], quo_ff);
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_SCORE;
               rsp_node_in   = orig[15:0];
               rsp_amount_in = sat_add(prod_ff[47:16], quo_ff);
               state_in = S_IDLE;
            end
         end
         S_RANGE_RD: begin
            e_in  = range_rd[33:17];
            hi_in = range_rd[16:0];
            state_in = S_E1;
         end
         S_E1: begin
            if ((e_ff < hi_ff) && !e_ff[EdgeW]) begin
               state_in = S_E2;
            end else if (act_ff == ACT_SEND) begin
               state_in = S_SEND_MSG;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_E2: begin
            // drop targets outside this partition
            if ((edge_rd >= {1'b0, first_ff}) && (tgt[16:LiW] == '0)) begin
               t_in = tgt[LiW-1:0];
               send_ra = tgt[LiW-1:0];
               recv_ra = tgt[LiW-1:0];
               state_in = S_E3;
            end else begin
               e_in = e_ff + 1'b1;
               state_in = S_E1;
            end
         end
         S_E3: begin
            if (act_ff == ACT_REMOTE) begin
               recv_we = 1'b1;
            end else begin
               send_we = 1'b1;
            end
            e_in = e_ff + 1'b1;
            state_in = S_E1;
         end
         S_SEND_MSG: begin
            rsp_strobe_in = 1'b1;
            if (!part_ff[15]) begin
               rsp_kind_in   = KIND_MSG;
               rsp_part_in   = part_ff[14:0];
               rsp_node_in   = orig[15:0];
               rsp_amount_in = quo_ff;
            end
            state_in = S_IDLE;
         end
         S_FIN_RD: begin
            sum_in = sat_add(send_rd, recv_rd);
            state_in = S_FIN_MUL;
         end
         S_FIN_MUL: begin
            // scale by 1 - d, then divide d into the teleport term
            prod_in  = sum_ff * (17'h10000 - {1'b0, damp_ff});
            quo_in   = {2'b00, damp_ff, 14'd0};
            dvs_in   = n_div;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 17'd65536;
         first_ff <= '0;
         damp_ff  <= 16'd9830;
         limit_ff <= 8'd10;
         state_ff <= S_CLR;
         prev_ff  <= '0;
         fill_ff  <= '0;
         iter_ff  <= '0;
         clr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         first_ff <= first_in;
         damp_ff  <= damp_in;
         limit_ff <= limit_in;
         state_ff <= state_in;
         prev_ff  <= prev_in;
         fill_ff  <= fill_in;
         iter_ff  <= iter_in;
         clr_ff   <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      act_ff  <= act_in;
      li_ff   <= li_in;
      imp_ff  <= imp_in;
      e_ff    <= e_in;
      hi_ff   <= hi_in;
      t_ff    <= t_in;
      part_ff <= part_in;
      flag_ff <= flag_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_part_ff   <= rsp_part_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_more_ff   <= rsp_more_in;
   end

endmodule
`default_nettype wire
